// ----- design/ccrs_pkg.sv -----
// Types and constants shared by the record ring selector and its CRC unit.
// No dependencies.
`timescale 1ns / 1ps

package ccrs_pkg;

   // Operation codes carried in the request opcode field.
   localparam logic [1:0] OP_SCAN  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   // Result status codes.
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NONE    = 2'd1;
   localparam logic [1:0] ST_WRITE   = 2'd2;
   localparam logic [1:0] ST_IGNORED = 2'd3;

   // CRC-16/CCITT-FALSE.
   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;

   localparam logic [7:0] VALID_CODE_RESET = 8'd1;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [2:0]  slot_index;
      logic [7:0]  record_state;
      logic [31:0] record_seq;
      logic [15:0] value_zero;
      logic [15:0] value_one;
      logic [15:0] value_two;
      logic [15:0] value_three;
      logic [15:0] stored_check;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        holds_valid;
      logic [2:0]  current_slot;
      logic [31:0] current_seq;
      logic [15:0] out_value_zero;
      logic [15:0] out_value_one;
      logic [15:0] out_value_two;
      logic [15:0] out_value_three;
      logic [2:0]  target_slot;
      logic [31:0] target_seq;
      logic [15:0] target_check;
   } rsp_type;

endpackage

// ----- design/crc_checked_record_ring_selector.sv -----
// Top level of the CRC-checked record ring selector.
// Depends on ccrs_pkg and ccrs_crc16.
`timescale 1ns / 1ps

// The block tracks the newest valid record in a ring of SLOT_COUNT storage slots.
// Each transaction is started by raising start while busy is low; busy never rises,
// so one transaction can be started in every clock cycle. A transaction is taken
// into an input register at the accepting edge and judged in one pass of
// combinational logic (one CRC unit, a sequence subtract and a value compare). Its
// result is registered at the next clock edge, so it sits on rsp_data, marked by
// rsp_strobe, for exactly one cycle and is taken by the receiver in that
// cycle. The receiver cannot stall, so every result must be captured in that
// cycle. Results come out in the order the transactions went in, one per
// transaction. The held record is updated at the same edge that registers the
// result, so the following transaction already sees it. A scan of slot 0 discards
// the held record before the scanned one is judged. The valid state code is written
// through the csr channel, which is always ready; write it only while no
// transaction is in flight.

module crc_checked_record_ring_selector
   import ccrs_pkg::*;
#(
   parameter int unsigned SLOT_COUNT = 8
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic [7:0] csr_data
);

   // Configuration register.
   logic [7:0] vsc_ff, vsc_in;

   // Input stage.
   req_type req_ff;
   logic    req_valid_ff, req_valid_in;

   // Held record.
   logic             has_ff, has_in;
   logic [2:0]       nslot_ff, nslot_in;
   logic [31:0]      nseq_ff, nseq_in;
   logic [3:0][15:0] nval_ff, nval_in;

   // Result stage.
   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff;

   // Datapath.
   logic [3:0][15:0] req_vals;
   logic             is_scan, clr;
   logic             eff_has;
   logic [31:0]      eff_seq;
   logic [31:0]      seq_diff;
   logic             newer, in_ring, take;
   logic             same;
   logic [3:0]       slot_inc;
   logic [2:0]       tslot;
   logic [31:0]      tseq;
   logic [31:0]      crc_seq;
   logic [15:0]      crc_out;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   assign vsc_in       = (csr_valid && csr_ready) ? csr_data : vsc_ff;
   assign req_valid_in = start && !busy;

   assign req_vals = {req_ff.value_three, req_ff.value_two,
                      req_ff.value_one, req_ff.value_zero};

   // Scan judgement. A scan of slot 0 sees an empty holder.
   assign is_scan  = (req_ff.opcode == OP_SCAN);
   assign clr      = is_scan && (req_ff.slot_index == 3'd0);
   assign eff_has  = clr ? 1'b0 : has_ff;
   assign eff_seq  = clr ? 32'd0 : nseq_ff;
   assign seq_diff = req_ff.record_seq - eff_seq;
   assign newer    = (seq_diff != 32'd0) && !seq_diff[31];
   assign in_ring  = ({4'd0, req_ff.slot_index} < 7'(SLOT_COUNT));
   assign take     = is_scan && in_ring && (req_ff.record_state == vsc_ff) &&
                     (crc_out == req_ff.stored_check) && (!eff_has || newer);

   // Write request: next slot round the ring and the following sequence number.
   assign same     = has_ff && (req_vals == nval_ff);
   assign slot_inc = {1'b0, nslot_ff} + 4'd1;
   assign tslot    = has_ff ? ((7'(slot_inc) == 7'(SLOT_COUNT)) ? 3'd0 : slot_inc[2:0])
                            : 3'd0;
   assign tseq     = has_ff ? (nseq_ff + 32'd1) : 32'd1;

   // One CRC unit serves both the scan check and the new record's check.
   assign crc_seq = is_scan ? req_ff.record_seq : tseq;

   ccrs_crc16 u_crc (
      .seq    (crc_seq),
      .values (req_vals),
      .check  (crc_out)
   );

   // Next held record.
   always_comb begin
      has_in   = has_ff;
      nslot_in = nslot_ff;
      nseq_in  = nseq_ff;
      nval_in  = nval_ff;
      if (req_valid_ff) begin
         if (take) begin
            has_in   = 1'b1;
            nslot_in = req_ff.slot_index;
            nseq_in  = req_ff.record_seq;
            nval_in  = req_vals;
         end else if (clr) begin
            has_in   = 1'b0;
            nslot_in = 3'd0;
            nseq_in  = 32'd0;
            nval_in  = '0;
         end
      end
   end

   // Result word, showing the held record as it stands after this transaction.
   always_comb begin
      rsp_in                 = '0;
      rsp_in.holds_valid     = has_in;
      rsp_in.current_slot    = has_in ? nslot_in : 3'd0;
      rsp_in.current_seq     = has_in ? nseq_in : 32'd0;
      rsp_in.out_value_zero  = has_in ? nval_in[0] : 16'd0;
      rsp_in.out_value_one   = has_in ? nval_in[1] : 16'd0;
      rsp_in.out_value_two   = has_in ? nval_in[2] : 16'd0;
      rsp_in.out_value_three = has_in ? nval_in[3] : 16'd0;
      case (req_ff.opcode)
         OP_SCAN: begin
            rsp_in.status = take ? ST_OK : ST_IGNORED;
         end
         OP_WRITE: begin
            if (same) begin
               rsp_in.status = ST_OK;
            end else begin
               rsp_in.status       = ST_WRITE;
               rsp_in.target_slot  = tslot;
               rsp_in.target_seq   = tseq;
               rsp_in.target_check = crc_out;
            end
         end
         OP_READ: begin
            rsp_in.status = has_ff ? ST_OK : ST_NONE;
         end
         default: begin
            rsp_in.status = ST_IGNORED;
         end
      endcase
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         vsc_ff       <= VALID_CODE_RESET;
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         has_ff       <= 1'b0;
         nslot_ff     <= 3'd0;
         nseq_ff      <= 32'd0;
         nval_ff      <= '0;
      end else begin
         vsc_ff       <= vsc_in;
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= req_valid_ff;
         has_ff       <= has_in;
         nslot_ff     <= nslot_in;
         nseq_ff      <= nseq_in;
         nval_ff      <= nval_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_valid_in) begin
         req_ff <= req_data;
      end
      if (req_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   // Every accepted transaction produces its result once its input and result registers are loaded.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_strobe)
      else $error("accepted transaction produced no result");

   // An empty holder reports zero for the current record.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.holds_valid) |->
         (rsp_data.current_seq == 32'd0 && rsp_data.current_slot == 3'd0))
      else $error("empty holder reported a current record");

   // Target fields are only filled when a write is needed.
   a_target_only_on_write: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status != ST_WRITE) |->
         (rsp_data.target_seq == 32'd0 && rsp_data.target_check == 16'd0))
      else $error("target fields set without write needed");

   // No valid record is reported only while nothing is held.
   a_none_means_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status == ST_NONE) |-> !rsp_data.holds_valid)
      else $error("no valid record reported while a record is held");

endmodule

// ----- design/ccrs_crc16.sv -----
// Combinational CRC-16/CCITT-FALSE over a record: big-endian sequence, then four values.
// Depends on ccrs_pkg for the polynomial and initial value.
`timescale 1ns / 1ps

module ccrs_crc16
   import ccrs_pkg::*;
(
   input  logic [31:0]      seq,
   input  logic [3:0][15:0] values,
   output logic [15:0]      check
);

   logic [95:0] msg;
   logic [15:0] crc;
   logic        fb;

   // Most significant bit first, which matches the byte-wise definition.
   assign msg = {seq, values[0], values[1], values[2], values[3]};

   always_comb begin
      crc = CRC_INIT;
      fb  = 1'b0;
      for (int i = 95; i >= 0; i--) begin
         fb  = crc[15] ^ msg[i];
         crc = {crc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
      end
   end

   assign check = crc;

endmodule

// ----- tb/tb_crc_checked_record_ring_selector.sv -----
// Self-checking testbench for the CRC-checked record ring selector: a directed table, then
// random scans, writes, reads and noise; results checked by a predictor or by hand.
// Depends on ccrs_pkg and the design top crc_checked_record_ring_selector.
`timescale 1ns / 1ps

module tb_crc_checked_record_ring_selector;
   import ccrs_pkg::*;

   // The design is built with eight slots, so every 3-bit slot index is in the ring.
   localparam int unsigned RING_SLOTS  = 8;
   localparam int unsigned PHASE_ITEMS = 190;

   // The design has no operation for opcode 3 and reports it as ignored; it is driven on purpose.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // One row of the directed table. Where fixed is set, the expected result is the
   // empty record with fixed_status, written in by hand; otherwise the predictor decides.
   typedef struct {
      req_type    req;
      bit         fixed;
      logic [1:0] fixed_status;
   } dir_row_type;

   // Image of one storage slot, as the firmware would find it in the EEPROM.
   typedef struct {
      logic [7:0]       state_byte;
      logic [31:0]      seq;
      logic [3:0][15:0] vals;
      logic [15:0]      check;
   } slot_image_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   logic [7:0] csr_data;

   // Predicted contents of the block: the valid state code and the held record.
   logic [7:0]       code_model  = VALID_CODE_RESET;
   logic             held_valid  = 1'b0;
   logic [2:0]       held_slot   = 3'd0;
   logic [31:0]      held_seq    = 32'd0;
   logic [3:0][15:0] held_vals   = '0;

   // Results still owed by the block, oldest first.
   rsp_type pending_results[$];
   rsp_type last_result;
   dir_row_type dir_rows[$];
   slot_image_type ring[RING_SLOTS];

   int  errors = 0;
   bit  steady = 1'b0;   // set during the stretch with no idling at all

   crc_checked_record_ring_selector #(
      .SLOT_COUNT (RING_SLOTS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard limit on the run, far beyond what a correct run needs.
   initial begin
      #(2_000_000);
      $display("crc_checked_record_ring_selector verification failed");
      $finish;
   end

   // CRC-16/CCITT-FALSE over the sequence and the four values, all big-endian. Taking
   // the 96 message bits most significant first is the same as the usual byte loop.
   function automatic logic [15:0] ccitt_false16(logic [31:0] seq, logic [3:0][15:0] vals);
      logic [95:0] msg;
      logic [15:0] crc;
      msg = {seq, vals[0], vals[1], vals[2], vals[3]};
      crc = CRC_INIT;
      for (int i = 95; i >= 0; i--) begin
         if (crc[15] ^ msg[i]) begin
            crc = {crc[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            crc = {crc[14:0], 1'b0};
         end
      end
      return crc;
   endfunction

   function automatic logic [3:0][15:0] values_of(req_type r);
      logic [3:0][15:0] v;
      v[0] = r.value_zero;
      v[1] = r.value_one;
      v[2] = r.value_two;
      v[3] = r.value_three;
      return v;
   endfunction

   function automatic req_type make_req(logic [1:0] op, logic [2:0] slot, logic [7:0] st,
                                        logic [31:0] seq, logic [3:0][15:0] v,
                                        logic [15:0] chk);
      req_type r;
      r.opcode       = op;
      r.slot_index   = slot;
      r.record_state = st;
      r.record_seq   = seq;
      r.value_zero   = v[0];
      r.value_one    = v[1];
      r.value_two    = v[2];
      r.value_three  = v[3];
      r.stored_check = chk;
      return r;
   endfunction

   // A scan transaction whose stored CRC matches its contents.
   function automatic req_type sealed_scan(logic [2:0] slot, logic [7:0] st,
                                           logic [31:0] seq, logic [3:0][15:0] v);
      return make_req(OP_SCAN, slot, st, seq, v, ccitt_false16(seq, v));
   endfunction

   // Works out the result of one accepted transaction and moves the predicted held
   // record on, exactly as the block does at the edge that registers the result.
   function automatic rsp_type judge_transaction(req_type r);
      rsp_type res;
      logic [3:0][15:0] v;
      logic [31:0] diff;
      v = values_of(r);
      res = '0;
      res.status = ST_IGNORED;
      case (r.opcode)
         OP_SCAN: begin
            // Slot 0 begins a fresh scan, so the held record goes before judging.
            if (r.slot_index == 3'd0) begin
               held_valid = 1'b0;
               held_slot  = 3'd0;
               held_seq   = 32'd0;
               held_vals  = '0;
            end
            diff = r.record_seq - held_seq;
            if (r.slot_index < RING_SLOTS && r.record_state == code_model &&
                ccitt_false16(r.record_seq, v) == r.stored_check &&
                (!held_valid || (diff != 32'd0 && !diff[31]))) begin
               held_valid = 1'b1;
               held_slot  = r.slot_index;
               held_seq   = r.record_seq;
               held_vals  = v;
               res.status = ST_OK;
            end
         end
         OP_WRITE: begin
            if (held_valid && v == held_vals) begin
               res.status = ST_OK;
            end else begin
               res.status = ST_WRITE;
               if (held_valid) begin
                  res.target_slot = 3'((held_slot + 1) % RING_SLOTS);
                  res.target_seq  = held_seq + 32'd1;
               end else begin
                  res.target_slot = 3'd0;
                  res.target_seq  = 32'd1;
               end
               res.target_check = ccitt_false16(res.target_seq, v);
            end
         end
         OP_READ: begin
            res.status = held_valid ? ST_OK : ST_NONE;
         end
         default: begin
         end
      endcase
      if (held_valid) begin
         res.holds_valid     = 1'b1;
         res.current_slot    = held_slot;
         res.current_seq     = held_seq;
         res.out_value_zero  = held_vals[0];
         res.out_value_one   = held_vals[1];
         res.out_value_two   = held_vals[2];
         res.out_value_three = held_vals[3];
      end
      return res;
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   // Results cannot be held off, so every strobe is taken at the edge ending its cycle
   // and compared with the oldest outstanding expectation.
   always @(posedge clock) begin : result_monitor
      rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: result with no transaction outstanding, actual %0h", $time,
                     rsp_data);
         end else begin
            want = pending_results.pop_front();
            check_field("status", want.status, rsp_data.status);
            check_field("holds_valid", want.holds_valid, rsp_data.holds_valid);
            check_field("current_slot", want.current_slot, rsp_data.current_slot);
            check_field("current_seq", want.current_seq, rsp_data.current_seq);
            check_field("out_value_zero", want.out_value_zero, rsp_data.out_value_zero);
            check_field("out_value_one", want.out_value_one, rsp_data.out_value_one);
            check_field("out_value_two", want.out_value_two, rsp_data.out_value_two);
            check_field("out_value_three", want.out_value_three, rsp_data.out_value_three);
            check_field("target_slot", want.target_slot, rsp_data.target_slot);
            check_field("target_seq", want.target_seq, rsp_data.target_seq);
            check_field("target_check", want.target_check, rsp_data.target_check);
         end
      end
   end

   // Offers one transaction and holds it until start is seen with busy low. The
   // expectation is formed at that edge. Afterwards the input may idle, each further idle
   // cycle coming with a chance of about one in four, except during the steady
   // stretch. When no idle cycle follows, start stays high so the next call does not
   // lower and raise it in one step.
   task automatic issue(req_type r, bit fixed, logic [1:0] fixed_status);
      rsp_type exp_res;
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      exp_res = judge_transaction(r);
      last_result = exp_res;
      if (fixed) begin
         exp_res = '0;
         exp_res.status = fixed_status;
      end
      pending_results.push_back(exp_res);
      if (!steady) begin
         while ($urandom_range(0, 99) < 26) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
   endtask

   // Lets every outstanding transaction come back, then idles on so that the block is idle.
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_code(logic [7:0] code);
      csr_valid <= 1'b1;
      csr_data  <= code;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      code_model = code;
   endtask

   task automatic add_row(req_type r, bit fixed, logic [1:0] fixed_status);
      dir_row_type row;
      row.req = r;
      row.fixed = fixed;
      row.fixed_status = fixed_status;
      dir_rows.push_back(row);
   endtask

   initial begin : stimulus
      logic [3:0][15:0] zero4;
      logic [3:0][15:0] ones4;
      logic [3:0][15:0] mix4;
      logic [3:0][15:0] v;
      logic [7:0]       code;
      logic [31:0]      base;
      logic [2:0]       scan_pos;
      logic [2:0]       slot;
      logic [127:0]     noise;
      req_type          r;
      int               pivot;
      int               pick;

      zero4 = '0;
      ones4 = '1;
      mix4  = {16'h7FFE, 16'h8001, 16'h0F0F, 16'hA5C3};

      reset     <= 1'b1;
      start     <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_data  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed table, run under the reset value of the valid state code.
      add_row(make_req(OP_READ, 3'd0, 8'd0, 32'd0, zero4, 16'd0), 1, ST_NONE);
      // Write when empty: slot 0, sequence 1.
      add_row(make_req(OP_WRITE, 3'd0, 8'd0, 32'd0, zero4, 16'd0), 0, ST_OK);
      add_row(make_req(OP_UNUSED, 3'd7, 8'hFF, 32'hFFFF_FFFF, ones4, 16'hFFFF), 1,
              ST_IGNORED);
      add_row(sealed_scan(3'd0, 8'd0, 32'd0, zero4), 1, ST_IGNORED);
      add_row(sealed_scan(3'd0, VALID_CODE_RESET, 32'd0, zero4), 0, ST_OK);
      add_row(sealed_scan(3'd1, VALID_CODE_RESET, 32'd1, ones4), 0, ST_OK);
      // Corrupted CRC, then an older and an equal sequence: none of them is taken.
      add_row(make_req(OP_SCAN, 3'd2, VALID_CODE_RESET, 32'd2, mix4,
                       ccitt_false16(32'd2, mix4) ^ 16'h0001), 0, ST_OK);
      add_row(sealed_scan(3'd3, VALID_CODE_RESET, 32'd0, zero4), 0, ST_OK);
      add_row(sealed_scan(3'd2, VALID_CODE_RESET, 32'd1, ones4), 0, ST_OK);
      add_row(make_req(OP_WRITE, 3'd0, 8'd0, 32'd0, ones4, 16'd0), 0, ST_OK);
      add_row(make_req(OP_WRITE, 3'd5, 8'hFF, 32'hFFFF_FFFF, mix4, 16'hFFFF), 0, ST_OK);
      add_row(make_req(OP_READ, 3'd7, 8'hFF, 32'hFFFF_FFFF, ones4, 16'hFFFF), 0, ST_OK);
      // Half a sequence space ahead is not newer; one less than that is.
      add_row(sealed_scan(3'd7, VALID_CODE_RESET, 32'h8000_0001, mix4), 0, ST_OK);
      add_row(sealed_scan(3'd7, VALID_CODE_RESET, 32'h8000_0000, mix4), 0, ST_OK);
      // Target slot wraps from the last slot of the ring to slot 0.
      add_row(make_req(OP_WRITE, 3'd0, 8'd0, 32'd0, zero4, 16'd0), 0, ST_OK);
      add_row(sealed_scan(3'd0, VALID_CODE_RESET, 32'hFFFF_FFFF, mix4), 0, ST_OK);
      // Target sequence wraps to zero.
      add_row(make_req(OP_WRITE, 3'd0, 8'd0, 32'd0, ones4, 16'd0), 0, ST_OK);
      // A slot-0 scan that fails still discards the held record.
      add_row(make_req(OP_SCAN, 3'd0, VALID_CODE_RESET, 32'd5, zero4, 16'd0), 1,
              ST_IGNORED);
      add_row(make_req(OP_READ, 3'd0, 8'd0, 32'd0, zero4, 16'd0), 1, ST_NONE);
      add_row(make_req(OP_SCAN, 3'd5, 8'hFF, 32'hFFFF_FFFF, ones4, 16'hFFFF), 1,
              ST_IGNORED);
      add_row(sealed_scan(3'd6, VALID_CODE_RESET, 32'h1234_5678, mix4), 0, ST_OK);
      add_row(sealed_scan(3'd4, VALID_CODE_RESET, 32'h1234_5677, ones4), 0, ST_OK);
      add_row(make_req(OP_UNUSED, 3'd2, 8'h01, 32'h1234_5679, zero4, 16'h0000), 0, ST_OK);
      add_row(make_req(OP_READ, 3'd0, 8'd0, 32'd0, zero4, 16'd0), 0, ST_OK);

      foreach (dir_rows[i]) begin
         issue(dir_rows[i].req, dir_rows[i].fixed, dir_rows[i].fixed_status);
      end
      settle();

      // Random phases, each under its own valid state code: both extremes, a random
      // code and finally the reset value written back. The second phase never idles.
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: code = 8'h00;
            1: code = 8'hFF;
            2: code = 8'($urandom_range(1, 254));
            default: code = VALID_CODE_RESET;
         endcase
         write_code(code);
         steady = (p == 1);

         // Fill the ring image with an ascending run of sequences that wraps at a
         // random slot, sometimes close to the signed or unsigned wrap point.
         case ($urandom_range(0, 2))
            0: base = $urandom;
            1: base = 32'h7FFF_FFFC - $urandom_range(0, 4);
            default: base = 32'hFFFF_FFFC - $urandom_range(0, 4);
         endcase
         pivot = $urandom_range(0, RING_SLOTS - 1);
         for (int s = 0; s < RING_SLOTS; s++) begin
            ring[s].seq   = base + 32'((s + RING_SLOTS - pivot) % RING_SLOTS);
            ring[s].vals  = {$urandom, $urandom};
            ring[s].check = ccitt_false16(ring[s].seq, ring[s].vals);
            ring[s].state_byte = ($urandom_range(0, 9) < 8) ? code :
                                 code ^ 8'($urandom_range(1, 255));
         end
         scan_pos = 3'd0;

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
               // Mostly an orderly walk round the ring, now and then a random slot.
               slot = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : scan_pos;
               scan_pos = scan_pos + 3'd1;
               r = make_req(OP_SCAN, slot, ring[slot].state_byte, ring[slot].seq,
                            ring[slot].vals, ring[slot].check);
               if ($urandom_range(0, 99) < 12) begin
                  case ($urandom_range(0, 3))
                     0: r.record_state ^= 8'(1 << $urandom_range(0, 7));
                     1: r.stored_check ^= 16'(1 << $urandom_range(0, 15));
                     2: r.record_seq ^= 32'd1 << $urandom_range(0, 31);
                     default: begin
                        // Well-formed but stale or equal to the held sequence.
                        r.record_seq = held_seq - $urandom_range(0, 3);
                        r.stored_check = ccitt_false16(r.record_seq, values_of(r));
                     end
                  endcase
               end
            end else if (pick < 75) begin
               v = ($urandom_range(0, 2) == 0) ? held_vals : {$urandom, $urandom};
               r = make_req(OP_WRITE, 3'($urandom), 8'($urandom), $urandom, v,
                            16'($urandom));
            end else if (pick < 90) begin
               r = make_req(OP_READ, 3'($urandom), 8'($urandom), $urandom,
                            {$urandom, $urandom}, 16'($urandom));
            end else begin
               noise = {$urandom, $urandom, $urandom, $urandom};
               r = noise[$bits(req_type)-1:0];
            end
            issue(r, 0, ST_OK);
            // The firmware usually commits the record that a write request asked for,
            // so that later scans find it in the ring.
            if (r.opcode == OP_WRITE && last_result.status == ST_WRITE &&
                $urandom_range(0, 9) != 0) begin
               ring[last_result.target_slot].state_byte = code_model;
               ring[last_result.target_slot].seq        = last_result.target_seq;
               ring[last_result.target_slot].vals       = values_of(r);
               ring[last_result.target_slot].check      = last_result.target_check;
            end
         end
         settle();
      end
      steady = 1'b0;

      if (errors == 0) begin
         $display("crc_checked_record_ring_selector verification clean");
      end else begin
         $display("crc_checked_record_ring_selector verification failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
design/ccrs_pkg.sv
design/ccrs_crc16.sv
design/crc_checked_record_ring_selector.sv
tb/tb_crc_checked_record_ring_selector.sv
